FILE: rtl/rrts_pkg.sv
// rrts_pkg: shared codes, field widths and control/status structs
// for the round-robin task ring scheduler; no dependencies
`default_nettype none

package rrts_pkg;

  // default ring size
  localparam int NUM_SLOTS_DEF = 16;

  // fixed field widths
  localparam int MODE_W     = 3;
  localparam int TGT_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int PID_W      = 5;
  localparam int SSTATE_W   = 2;

  // request modes (mode 6 and the unused code 7 only report)
  localparam logic [MODE_W-1:0] MODE_CREATE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SCHEDULE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNBLOCK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_KILL     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EXIT     = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_TGT = 2'd2;

  // per-slot task state
  localparam logic [SSTATE_W-1:0] SST_RUN     = 2'd1;
  localparam logic [SSTATE_W-1:0] SST_BLOCKED = 2'd2;
  localparam logic [SSTATE_W-1:0] SST_ZOMBIE  = 2'd3;

  // shared read address select
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_CUR  = 2'd1;
  localparam logic [1:0] RD_LINK = 2'd2;

  // slot state write select
  localparam logic [2:0] STW_NONE = 3'd0;
  localparam logic [2:0] STW_INIT = 3'd1;
  localparam logic [2:0] STW_CUR  = 3'd2;
  localparam logic [2:0] STW_TGT  = 3'd3;
  localparam logic [2:0] STW_NEW  = 3'd4;

  // successor write select
  localparam logic [1:0] SCW_NONE = 2'd0;
  localparam logic [1:0] SCW_INIT = 2'd1;
  localparam logic [1:0] SCW_NEW  = 2'd2;
  localparam logic [1:0] SCW_HEAD = 2'd3;

  // result slot select
  localparam logic [1:0] RES_CUR  = 2'd0;
  localparam logic [1:0] RES_WALK = 2'd1;
  localparam logic [1:0] RES_NEW  = 2'd2;

  typedef struct packed {
    logic                accept;
    logic [1:0]          rd_sel;
    logic [2:0]          st_wsel;
    logic [SSTATE_W-1:0] st_wval;
    logic [1:0]          sc_wsel;
    logic                used_inc;
    logic                walk_load;
    logic                cur_load;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic [1:0]          res_sel;
    logic                out_switched;
  } rrts_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              tgt_bad;
    logic              link_is_cur;
    logic              node_run;
  } rrts_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rrts_ram.sv
// rrts_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/rrts_ctrl.sv
// rrts_ctrl: sequencing state machine of the task ring scheduler
// depends on rrts_pkg for command/status structs and codes
`default_nettype none

module rrts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  output      logic               out_valid,
  input  wire logic               out_stall,
  input  wire rrts_pkg::rrts_stat_t stat,
  output      rrts_pkg::rrts_cmd_t  cmd
);

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DECODE  = 3'd2;
  localparam logic [2:0] S_HEAD    = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_CR_LINK = 3'd5;
  localparam logic [2:0] S_CR_HEAD = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel     = rrts_pkg::RD_ZERO;
    cmd.st_wsel    = rrts_pkg::STW_NONE;
    cmd.sc_wsel    = rrts_pkg::SCW_NONE;
    cmd.out_status = rrts_pkg::STATUS_OK;
    cmd.res_sel    = rrts_pkg::RES_CUR;
    case (state_r)
      S_INIT: begin
        // slot 0 runs and links to itself
        cmd.st_wsel = rrts_pkg::STW_INIT;
        cmd.sc_wsel = rrts_pkg::SCW_INIT;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          rrts_pkg::MODE_CREATE: begin
            if (stat.full) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = rrts_pkg::STATUS_FULL;
              state_nxt      = S_IDLE;
            end else begin
              cmd.rd_sel = rrts_pkg::RD_ZERO;
              state_nxt  = S_CR_LINK;
            end
          end
          rrts_pkg::MODE_SCHEDULE: begin
            cmd.rd_sel = rrts_pkg::RD_CUR;
            state_nxt  = S_HEAD;
          end
          rrts_pkg::MODE_BLOCK, rrts_pkg::MODE_EXIT: begin
            cmd.st_wsel = rrts_pkg::STW_CUR;
            cmd.st_wval = (stat.mode == rrts_pkg::MODE_BLOCK) ?
                          rrts_pkg::SST_BLOCKED : rrts_pkg::SST_ZOMBIE;
            cmd.rd_sel  = rrts_pkg::RD_CUR;
            state_nxt   = S_HEAD;
          end
          rrts_pkg::MODE_UNBLOCK, rrts_pkg::MODE_KILL: begin
            cmd.out_load = 1'b1;
            if (stat.tgt_bad) begin
              cmd.out_status = rrts_pkg::STATUS_BAD_TGT;
            end else begin
              cmd.st_wsel = rrts_pkg::STW_TGT;
              cmd.st_wval = (stat.mode == rrts_pkg::MODE_UNBLOCK) ?
                            rrts_pkg::SST_RUN : rrts_pkg::SST_ZOMBIE;
            end
            state_nxt = S_IDLE;
          end
          default: begin
            // query and the unused code just report
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_HEAD: begin
        if (stat.link_is_cur) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_sel    = rrts_pkg::RD_LINK;
          cmd.walk_load = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.node_run) begin
          cmd.cur_load     = 1'b1;
          cmd.out_load     = 1'b1;
          cmd.res_sel      = rrts_pkg::RES_WALK;
          cmd.out_switched = 1'b1;
          state_nxt        = S_IDLE;
        end else if (stat.link_is_cur) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_sel    = rrts_pkg::RD_LINK;
          cmd.walk_load = 1'b1;
        end
      end
      S_CR_LINK: begin
        // new slot inherits the old successor of slot 0
        cmd.sc_wsel = rrts_pkg::SCW_NEW;
        state_nxt   = S_CR_HEAD;
      end
      S_CR_HEAD: begin
        cmd.sc_wsel  = rrts_pkg::SCW_HEAD;
        cmd.st_wsel  = rrts_pkg::STW_NEW;
        cmd.used_inc = 1'b1;
        cmd.out_load = 1'b1;
        cmd.res_sel  = rrts_pkg::RES_NEW;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rrts_dp.sv
// rrts_dp: ring datapath, slot state and successor memories, current slot,
// fill count and result register; depends on rrts_pkg and rrts_ram
`default_nettype none

module rrts_dp #(
  parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rrts_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [rrts_pkg::TGT_W-1:0]      in_target_slot,
  input  wire rrts_pkg::rrts_cmd_t             cmd,
  output      rrts_pkg::rrts_stat_t            stat,
  output      logic [rrts_pkg::STATUS_W-1:0]   out_status,
  output      logic [rrts_pkg::SLOT_OUT_W-1:0] out_result_slot,
  output      logic [rrts_pkg::PID_W-1:0]      out_task_pid,
  output      logic                            out_switched,
  output      logic [rrts_pkg::SLOT_OUT_W-1:0] out_prev_slot
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int USED_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = (USED_W > rrts_pkg::TGT_W) ? USED_W : rrts_pkg::TGT_W;

  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [SLOT_W-1:0] walk_r;
  logic [rrts_pkg::MODE_W-1:0] mode_r;
  logic [rrts_pkg::TGT_W-1:0]  tgt_r;
  logic [SLOT_W-1:0] prev_r;

  logic [SLOT_W-1:0]             raddr;
  logic                          st_we;
  logic [SLOT_W-1:0]             st_waddr;
  logic [rrts_pkg::SSTATE_W-1:0] st_wdata;
  logic [rrts_pkg::SSTATE_W-1:0] st_rdata;
  logic                          sc_we;
  logic [SLOT_W-1:0]             sc_waddr;
  logic [SLOT_W-1:0]             sc_wdata;
  logic [SLOT_W-1:0]             sc_rdata;

  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W:0]   res_pid;

  assign new_slot = SLOT_W'(used_r);

  always_comb begin
    case (cmd.rd_sel)
      rrts_pkg::RD_CUR:  raddr = cur_r;
      rrts_pkg::RD_LINK: raddr = sc_rdata;
      default:           raddr = '0;
    endcase
  end

  always_comb begin
    st_we    = 1'b1;
    st_waddr = '0;
    st_wdata = cmd.st_wval;
    case (cmd.st_wsel)
      rrts_pkg::STW_INIT: st_wdata = rrts_pkg::SST_RUN;
      rrts_pkg::STW_CUR:  st_waddr = cur_r;
      rrts_pkg::STW_TGT:  st_waddr = SLOT_W'(tgt_r);
      rrts_pkg::STW_NEW: begin
        st_waddr = new_slot;
        st_wdata = rrts_pkg::SST_RUN;
      end
      default: st_we = 1'b0;
    endcase
  end

  always_comb begin
    sc_we    = 1'b1;
    sc_waddr = '0;
    sc_wdata = '0;
    case (cmd.sc_wsel)
      rrts_pkg::SCW_INIT: sc_wdata = '0;
      rrts_pkg::SCW_NEW: begin
        sc_waddr = new_slot;
        sc_wdata = sc_rdata;
      end
      rrts_pkg::SCW_HEAD: sc_wdata = new_slot;
      default: sc_we = 1'b0;
    endcase
  end

  rrts_ram #(
    .WIDTH (rrts_pkg::SSTATE_W),
    .DEPTH (NUM_SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  rrts_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_succ_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (raddr),
    .rdata (sc_rdata)
  );

  assign stat.mode        = mode_r;
  assign stat.full        = (used_r == USED_W'(NUM_SLOTS));
  assign stat.tgt_bad     = (CMP_W'(tgt_r) >= CMP_W'(used_r));
  assign stat.link_is_cur = (sc_rdata == cur_r);
  assign stat.node_run    = (st_rdata == rrts_pkg::SST_RUN);

  always_comb begin
    case (cmd.res_sel)
      rrts_pkg::RES_WALK: res_slot = walk_r;
      rrts_pkg::RES_NEW:  res_slot = new_slot;
      default:            res_slot = cur_r;
    endcase
  end

  assign res_pid  = (SLOT_W + 1)'(res_slot) + (SLOT_W + 1)'(1);
  assign cur_nxt  = cmd.cur_load ? walk_r : cur_r;
  assign used_nxt = cmd.used_inc ? used_r + USED_W'(1) : used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      used_r <= USED_W'(1);
    end else begin
      cur_r  <= cur_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      tgt_r  <= in_target_slot;
      prev_r <= cur_r;
    end
    if (cmd.walk_load) begin
      walk_r <= sc_rdata;
    end
    if (cmd.out_load) begin
      out_status      <= cmd.out_status;
      out_result_slot <= rrts_pkg::SLOT_OUT_W'(res_slot);
      out_task_pid    <= rrts_pkg::PID_W'(res_pid);
      out_switched    <= cmd.out_switched;
      out_prev_slot   <= rrts_pkg::SLOT_OUT_W'(prev_r);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/round_robin_task_ring_scheduler.sv
// round_robin_task_ring_scheduler: top level, joins the sequencing fsm and
// the ring datapath; depends on rrts_pkg, rrts_ctrl, rrts_dp, rrts_ram
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  mode, target_slot
//   out_     output     out_valid/out_stall status, result_slot, task_pid,
//                                          switched, prev_slot
//
// one request at a time: accept, decode, then per mode
//   create links the new slot in; unblock/kill/query and full create
//   report from decode; schedule/block/exit read the head, then walk
//   up to used slots - 1 ring nodes, one successor memory read per node
// after reset the init state seeds slot 0 (runnable, linked to itself)
// before the first transfer is taken
// the result register holds a stalled result; the next request is taken
// in the cycle that result transfers
`default_nettype none

module round_robin_task_ring_scheduler #(
  parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [rrts_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [rrts_pkg::TGT_W-1:0]      in_target_slot,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [rrts_pkg::STATUS_W-1:0]   out_status,
  output      logic [rrts_pkg::SLOT_OUT_W-1:0] out_result_slot,
  output      logic [rrts_pkg::PID_W-1:0]      out_task_pid,
  output      logic                            out_switched,
  output      logic [rrts_pkg::SLOT_OUT_W-1:0] out_prev_slot
);

  // command and status between fsm and datapath
  rrts_pkg::rrts_cmd_t  cmd;
  rrts_pkg::rrts_stat_t stat;

  // sequencing: accept, decode, ring walk, create linking
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot memories, current slot, fill count and result register
  rrts_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_target_slot  (in_target_slot),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .out_task_pid    (out_task_pid),
    .out_switched    (out_switched),
    .out_prev_slot   (out_prev_slot)
  );

endmodule

`default_nettype wire
